[rtl/msgpack_value_encoder_top_macros.svh]
// Assertion macros shared by the encoder checker.
`ifndef MSGPACK_VALUE_ENCODER_TOP_MACROS_SVH
`define MSGPACK_VALUE_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MVE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MVE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mve_pkg.sv]
// Types and constants for the MessagePack value encoder.
package mve_pkg;

   localparam logic [3:0] OP_MAP      = 4'd0;
   localparam logic [3:0] OP_ARRAY    = 4'd1;
   localparam logic [3:0] OP_STR_HDR  = 4'd2;
   localparam logic [3:0] OP_STR_BYTE = 4'd3;
   localparam logic [3:0] OP_UINT8    = 4'd4;
   localparam logic [3:0] OP_UINT32   = 4'd5;
   localparam logic [3:0] OP_UINT64   = 4'd6;
   localparam logic [3:0] OP_FLOAT32  = 4'd7;
   localparam logic [3:0] OP_FINISH   = 4'd8;

   localparam logic [7:0] MP_FIXMAP   = 8'h80;
   localparam logic [7:0] MP_FIXARRAY = 8'h90;
   localparam logic [7:0] MP_ARRAY16  = 8'hDC;
   localparam logic [7:0] MP_FIXSTR   = 8'hA0;
   localparam logic [7:0] MP_UINT8    = 8'hCC;
   localparam logic [7:0] MP_UINT32   = 8'hCE;
   localparam logic [7:0] MP_UINT64   = 8'hCF;
   localparam logic [7:0] MP_FLOAT32  = 8'hCA;
   localparam logic [7:0] MP_FIXINT_MAX = 8'h7F;
   localparam logic [15:0] MP_FIXARRAY_MAX = 16'd15;

   localparam logic [15:0] CAPACITY_RESET = 16'd4096;

   // Command kinds passed from front to back.
   localparam logic [1:0] KIND_BYTES  = 2'd0;
   localparam logic [1:0] KIND_STATUS = 2'd1;
   localparam logic [1:0] KIND_FAIL   = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [3:0]       count;   // bytes to emit, 1..9 for KIND_BYTES
      logic [8:0][7:0]  bytes;   // byte 0 goes out first
   } mve_cmd_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        is_status;
      logic        last;
      logic        frame_ok;
      logic [15:0] frame_size;
   } mve_rsp_type;

endpackage

[rtl/mve_front.sv]
// Front end: decodes one input item into a byte command.
module mve_front
   import mve_pkg::*;
(
   input  logic [3:0]  op,
   input  logic [63:0] value,
   output logic        cmd_valid,
   output mve_cmd_type cmd
);

   always_comb begin
      cmd_valid = 1'b1;
      cmd.kind  = KIND_BYTES;
      cmd.count = 4'd1;
      cmd.bytes = '0;
      case (op)
         OP_MAP: begin
            cmd.bytes[0] = MP_FIXMAP | {4'd0, value[3:0]};
         end
         OP_ARRAY: begin
            if (value[15:0] <= MP_FIXARRAY_MAX) begin
               cmd.bytes[0] = MP_FIXARRAY | {4'd0, value[3:0]};
            end else begin
               cmd.count    = 4'd3;
               cmd.bytes[0] = MP_ARRAY16;
               cmd.bytes[1] = value[15:8];
               cmd.bytes[2] = value[7:0];
            end
         end
         OP_STR_HDR: begin
            if (value[63:5] != '0) begin
               cmd.kind  = KIND_FAIL;
               cmd.count = 4'd0;
            end else begin
               cmd.bytes[0] = MP_FIXSTR | {3'd0, value[4:0]};
            end
         end
         OP_STR_BYTE: begin
            cmd.bytes[0] = value[7:0];
         end
         OP_UINT8: begin
            if (value[7:0] <= MP_FIXINT_MAX) begin
               cmd.bytes[0] = value[7:0];
            end else begin
               cmd.count    = 4'd2;
               cmd.bytes[0] = MP_UINT8;
               cmd.bytes[1] = value[7:0];
            end
         end
         OP_UINT32, OP_FLOAT32: begin
            cmd.count    = 4'd5;
            cmd.bytes[0] = (op == OP_UINT32) ? MP_UINT32 : MP_FLOAT32;
            cmd.bytes[1] = value[31:24];
            cmd.bytes[2] = value[23:16];
            cmd.bytes[3] = value[15:8];
            cmd.bytes[4] = value[7:0];
         end
         OP_UINT64: begin
            cmd.count    = 4'd9;
            cmd.bytes[0] = MP_UINT64;
            cmd.bytes[1] = value[63:56];
            cmd.bytes[2] = value[55:48];
            cmd.bytes[3] = value[47:40];
            cmd.bytes[4] = value[39:32];
            cmd.bytes[5] = value[31:24];
            cmd.bytes[6] = value[23:16];
            cmd.bytes[7] = value[15:8];
            cmd.bytes[8] = value[7:0];
         end
         OP_FINISH: begin
            cmd.kind  = KIND_STATUS;
            cmd.count = 4'd0;
         end
         default: begin
            // unknown op: dropped
            cmd_valid = 1'b0;
            cmd.count = 4'd0;
         end
      endcase
   end

endmodule

[rtl/mve_cmd_fifo.sv]
// Command queue between the decode front and the byte emitter.
module mve_cmd_fifo
   import mve_pkg::*;
#(
   parameter int DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        wr_en,
   input  mve_cmd_type wr_data,
   input  logic        rd_en,
   output mve_cmd_type rd_data,
   output logic        full,
   output logic        empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mve_cmd_type          slot_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 do_wr, do_rd;

   assign full    = (cnt_ff == CNT_W'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

[rtl/mve_back.sv]
// Back end: frame accounting and result emission, one byte per cycle while the result channel does not stall.
module mve_back
   import mve_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic [15:0] capacity,
   input  logic        cmd_empty,
   input  mve_cmd_type cmd,
   output logic        cmd_pop,
   output logic        rsp_valid,
   input  logic        rsp_pop,
   output mve_rsp_type rsp
);

   logic [15:0] cnt_ff, cnt_in;
   logic        good_ff, good_in;
   logic [3:0]  idx_ff, idx_in;
   logic        valid_ff, valid_in;
   mve_rsp_type rsp_ff, rsp_in;
   logic        can_go, emit;
   logic [15:0] cnt_inc;
   logic        at_end, hit_cap, byte_ok;

   assign can_go  = !cmd_empty && (!valid_ff || rsp_pop);
   assign cnt_inc = cnt_ff + 16'd1;
   assign at_end  = ((idx_ff + 4'd1) == cmd.count);
   assign hit_cap = (cnt_inc >= capacity);
   assign byte_ok = good_ff && (cnt_ff < capacity);

   always_comb begin
      cnt_in  = cnt_ff;
      good_in = good_ff;
      idx_in  = idx_ff;
      rsp_in  = rsp_ff;
      emit    = 1'b0;
      cmd_pop = 1'b0;
      if (can_go) begin
         case (cmd.kind)
            KIND_STATUS: begin
               emit              = 1'b1;
               cmd_pop           = 1'b1;
               rsp_in.data_byte  = '0;
               rsp_in.is_status  = 1'b1;
               rsp_in.last       = 1'b1;
               rsp_in.frame_ok   = good_ff;
               rsp_in.frame_size = good_ff ? cnt_ff : '0;
               cnt_in            = '0;
               good_in           = 1'b1;
               idx_in            = '0;
            end
            KIND_FAIL: begin
               cmd_pop = 1'b1;
               good_in = 1'b0;
               idx_in  = '0;
            end
            KIND_BYTES: begin
               if (!byte_ok) begin
                  // frame already failed or full: drop rest of word
                  cmd_pop = 1'b1;
                  good_in = 1'b0;
                  idx_in  = '0;
               end else begin
                  emit              = 1'b1;
                  rsp_in.data_byte  = cmd.bytes[idx_ff];
                  rsp_in.is_status  = 1'b0;
                  rsp_in.last       = at_end || hit_cap;
                  rsp_in.frame_ok   = 1'b1;
                  rsp_in.frame_size = cnt_inc;
                  cnt_in            = cnt_inc;
                  if (at_end) begin
                     cmd_pop = 1'b1;
                     idx_in  = '0;
                  end else if (hit_cap) begin
                     // next byte of this word would overflow
                     cmd_pop = 1'b1;
                     good_in = 1'b0;
                     idx_in  = '0;
                  end else begin
                     idx_in = idx_ff + 4'd1;
                  end
               end
            end
            default: begin
               cmd_pop = 1'b1;
               idx_in  = '0;
            end
         endcase
      end
      valid_in = emit ? 1'b1 : (rsp_pop ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         good_ff  <= 1'b1;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         good_ff  <= good_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = rsp_ff;

endmodule

[rtl/msgpack_value_encoder_top.sv]
// MessagePack value encoder: top level with capacity register.
// With queue and emitter idle, the first result of a word passes through the
// command queue and then the emitter's output register before it shows on the ports.
// Output runs at one byte per cycle while the result channel does not stall; a
// word gives up to 9 bytes for a uint64. The emitter's single byte lane sets this rate.
// Input is taken whenever the command queue has room. Sync active-high reset:
// queue empty, frame count 0, frame good, capacity 4096.
module msgpack_value_encoder_top
   import mve_pkg::*;
#(
   parameter int QUEUE_DEPTH = 2
)
(
   input  logic        clock,
   input  logic        reset,
   // input word channel
   input  logic        push,
   output logic        full,
   input  logic [3:0]  req_op,
   input  logic [63:0] req_value,
   // result channel
   output logic        empty,
   input  logic        pop,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_is_status,
   output logic        rsp_last,
   output logic        rsp_frame_ok,
   output logic [15:0] rsp_frame_size,
   // capacity register
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic [15:0] capacity_ff, capacity_in;
   logic        cmd_valid;
   mve_cmd_type cmd_new;
   mve_cmd_type cmd_head;
   logic        cmd_empty, cmd_full, cmd_pop;
   logic        rsp_valid;
   mve_rsp_type rsp;

   // Capacity is to be rewritten only while the block is idle; the block does not enforce this.
   assign capacity_in = csr_wr_en ? csr_wr_data : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   // Decode: unknown ops are taken but produce no command.
   mve_front u_front (
      .op        (req_op),
      .value     (req_value),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_new)
   );

   mve_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (push && cmd_valid),
      .wr_data (cmd_new),
      .rd_en   (cmd_pop),
      .rd_data (cmd_head),
      .full    (cmd_full),
      .empty   (cmd_empty)
   );

   assign full = cmd_full;

   // Emitter: frame count, fail flag, output register.
   mve_back u_back (
      .clock     (clock),
      .reset     (reset),
      .capacity  (capacity_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_valid),
      .rsp_pop   (pop),
      .rsp       (rsp)
   );

   assign empty          = !rsp_valid;
   assign rsp_data_byte  = rsp.data_byte;
   assign rsp_is_status  = rsp.is_status;
   assign rsp_last       = rsp.last;
   assign rsp_frame_ok   = rsp.frame_ok;
   assign rsp_frame_size = rsp.frame_size;

endmodule

[rtl/mve_checker.sv]
// Port-level checker for the encoder, bound to the top level.
`include "msgpack_value_encoder_top_macros.svh"

module mve_checker (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_is_status,
   input logic        rsp_last,
   input logic        rsp_frame_ok,
   input logic [15:0] rsp_frame_size
);

   `MVE_ASSERT_NEXT(a_rsp_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_data_byte) && $stable(rsp_frame_size), "result changed while stalled")

   `MVE_ASSERT_NOW(a_status_form, clock, reset, !empty && rsp_is_status, rsp_data_byte == 8'd0 && rsp_last, "status word malformed")

   `MVE_ASSERT_NOW(a_byte_ok, clock, reset, !empty && !rsp_is_status, rsp_frame_ok && rsp_frame_size != 16'd0, "byte word without good frame count")

   `MVE_ASSERT_NOW(a_fail_size, clock, reset, !empty && rsp_is_status && !rsp_frame_ok, rsp_frame_size == 16'd0, "failed frame reports nonzero size")

endmodule

bind msgpack_value_encoder_top mve_checker u_mve_checker (.*);
